@@ rtl/core/linear_probe_hash_map_assert.svh @@
// Assertion macros for the hash map core.
// Used by lphm_ctrl; expect clock and reset in the including module's scope.
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`ifndef SYNTHESIS
`define LPHM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lphm: same-cycle check failed");
`define LPHM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lphm: next-cycle check failed");
`else
`define LPHM_ASSERT_IMPL(label, ante, cons)
`define LPHM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/lphm_pkg.sv @@
// Shared types and constants of the hash map core.
// No dependencies.
`default_nettype none

package lphm_pkg;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 16;
   localparam int VALUE_W  = 63;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 3;
   localparam int HASH_W   = 28;

   localparam logic [14:0] HASH_MUL_ROW = 15'd31371;
   localparam logic [11:0] HASH_MUL_COL = 12'd2689;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic               used;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;
endpackage

`default_nettype wire

@@ rtl/core/lphm_req_if.sv @@
// Request channel: valid/ready handshake carrying one operation item.
// Depends on lphm_pkg.
`default_nettype none

interface lphm_req_if;
   import lphm_pkg::*;
   logic               valid;
   logic               ready;
   logic               func;
   logic [ROW_W-1:0]   key_row;
   logic [COL_W-1:0]   key_col;
   logic [VALUE_W-1:0] value_in;

   modport source (output valid, func, key_row, key_col, value_in, input ready);
   modport sink   (input valid, func, key_row, key_col, value_in, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lphm_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result item.
// Depends on lphm_pkg.
`default_nettype none

interface lphm_rsp_if;
   import lphm_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [VALUE_W-1:0]  value_out;

   modport source (output valid, status, slot, value_out, input ready);
   modport sink   (input valid, status, slot, value_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lphm_hash.sv @@
// Home slot unit: (row*31371 + col*2689) mod TABLE_DEPTH.
// Power-of-two depth: a registered mask. Otherwise the per-byte remainder ROM outputs are registered, then
// a three-way add with a final reduction is registered. Uses lphm_pkg.
`default_nettype none

module lphm_hash #(
   parameter int TABLE_DEPTH = 1024,
   parameter int IDX_W       = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lphm_pkg::ROW_W-1:0] key_row,
   input  logic [lphm_pkg::COL_W-1:0] key_col,
   output logic                       done,
   output logic [IDX_W-1:0]           home
);
   import lphm_pkg::*;

   localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         logic [HASH_W-1:0] sum;
         logic              done_ff;
         logic [IDX_W-1:0]  home_ff;

         assign sum = HASH_W'(key_row) * HASH_W'(HASH_MUL_ROW)
                    + HASH_W'(key_col) * HASH_W'(HASH_MUL_COL);

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               home_ff <= sum[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_rom
         localparam int ROW_N = 2 ** ROW_W;
         localparam int COL_H = COL_W / 2;
         localparam int COL_N = 2 ** COL_H;
         localparam logic [IDX_W+1:0] DEP_1 = (IDX_W + 2)'(TABLE_DEPTH);
         localparam logic [IDX_W+1:0] DEP_2 = (IDX_W + 2)'(2 * TABLE_DEPTH);

         logic [IDX_W-1:0] row_rom [ROW_N];
         logic [IDX_W-1:0] hi_rom  [COL_N];
         logic [IDX_W-1:0] lo_rom  [COL_N];
         logic             part_ok_ff;
         logic             done_ff;
         logic [IDX_W-1:0] row_part_ff, hi_part_ff, lo_part_ff;
         logic [IDX_W+1:0] part_sum;
         logic [IDX_W-1:0] home_ff, home_in;

         // each key byte's contribution, already reduced mod depth
         for (genvar i = 0; i < ROW_N; i++) begin : g_row
            assign row_rom[i] = IDX_W'((i * int'(HASH_MUL_ROW)) % TABLE_DEPTH);
         end
         for (genvar i = 0; i < COL_N; i++) begin : g_col
            assign hi_rom[i] = IDX_W'((i * COL_N * int'(HASH_MUL_COL)) % TABLE_DEPTH);
            assign lo_rom[i] = IDX_W'((i * int'(HASH_MUL_COL)) % TABLE_DEPTH);
         end

         assign part_sum = (IDX_W + 2)'(row_part_ff) + (IDX_W + 2)'(hi_part_ff)
                         + (IDX_W + 2)'(lo_part_ff);

         always_comb begin
            if (part_sum >= DEP_2) begin
               home_in = IDX_W'(part_sum - DEP_2);
            end else if (part_sum >= DEP_1) begin
               home_in = IDX_W'(part_sum - DEP_1);
            end else begin
               home_in = part_sum[IDX_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               part_ok_ff <= 1'b0;
               done_ff    <= 1'b0;
            end else begin
               part_ok_ff <= start;
               done_ff    <= part_ok_ff;
            end
            if (start) begin
               row_part_ff <= row_rom[key_row];
               hi_part_ff  <= hi_rom[key_col[COL_W-1:COL_H]];
               lo_part_ff  <= lo_rom[key_col[COL_H-1:0]];
            end
            if (part_ok_ff) begin
               home_ff <= home_in;
            end
         end

         assign done = done_ff;
         assign home = home_ff;
      end
   endgenerate
endmodule

`default_nettype wire

@@ rtl/core/lphm_mem.sv @@
// Slot memory: one write port, one read port, registered read data.
// Uses lphm_pkg entry and control types.
`default_nettype none

module lphm_mem #(
   parameter int TABLE_DEPTH = 1024,
   parameter int IDX_W       = 10
) (
   input  logic                  clock,
   input  lphm_pkg::mem_ctl_type ctl,
   input  logic [IDX_W-1:0]      wr_addr,
   input  lphm_pkg::entry_type   wr_data,
   input  logic [IDX_W-1:0]      rd_addr,
   output lphm_pkg::entry_type   rd_data
);
   import lphm_pkg::*;

   entry_type mem [0:TABLE_DEPTH-1];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

@@ rtl/core/lphm_ctrl.sv @@
// Probe sequencer: clearing sweep, linear probing, entry count, result register.
// Uses lphm_pkg, lphm_req_if, lphm_rsp_if and the assertion macros.
`default_nettype none
`include "linear_probe_hash_map_assert.svh"

module lphm_ctrl #(
   parameter int TABLE_DEPTH = 1024,
   parameter int IDX_W       = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   lphm_req_if.sink                   req_if,
   lphm_rsp_if.source                 rsp_if,
   output logic                       hash_start,
   output logic [lphm_pkg::ROW_W-1:0] hash_row,
   output logic [lphm_pkg::COL_W-1:0] hash_col,
   input  logic                       hash_done,
   input  logic [IDX_W-1:0]           hash_home,
   output lphm_pkg::mem_ctl_type      mem_ctl,
   output logic [IDX_W-1:0]           mem_wr_addr,
   output lphm_pkg::entry_type        mem_wr_data,
   output logic [IDX_W-1:0]           mem_rd_addr,
   input  lphm_pkg::entry_type        mem_rd_data
);
   import lphm_pkg::*;

   localparam int HALF  = TABLE_DEPTH / 2;
   localparam int CNT_W = $clog2(HALF + 1);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   func_type           op_func_ff, op_func_in;
   logic [ROW_W-1:0]   op_row_ff, op_row_in;
   logic [COL_W-1:0]   op_col_ff, op_col_in;
   logic [VALUE_W-1:0] op_value_ff, op_value_in;
   logic [IDX_W-1:0]   probe_addr_ff, probe_addr_in;
   logic [IDX_W-1:0]   probe_cnt_ff, probe_cnt_in;
   status_type         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic             hit;
   logic             insert_op;
   logic [IDX_W-1:0] next_addr;

   assign hit = mem_rd_data.used && (mem_rd_data.row == op_row_ff)
             && (mem_rd_data.col == op_col_ff);
   assign insert_op = (op_func_ff == FUNC_INSERT);
   assign next_addr = (probe_addr_ff == LAST) ? '0 : probe_addr_ff + 1'b1;

   assign hash_row = req_if.key_row;
   assign hash_col = req_if.key_col;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cnt_in        = cnt_ff;
      op_func_in    = op_func_ff;
      op_row_in     = op_row_ff;
      op_col_in     = op_col_ff;
      op_value_in   = op_value_ff;
      probe_addr_in = probe_addr_ff;
      probe_cnt_in  = probe_cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;

      req_if.ready = (state_ff == S_IDLE);
      hash_start   = 1'b0;
      mem_ctl      = '0;
      mem_wr_addr  = probe_addr_ff;
      mem_wr_data  = {1'b1, op_row_ff, op_col_ff, op_value_ff};
      mem_rd_addr  = probe_addr_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = clr_addr_ff;
            mem_wr_data   = '0;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               op_func_in  = func_type'(req_if.func);
               op_row_in   = req_if.key_row;
               op_col_in   = req_if.key_col;
               op_value_in = req_if.value_in;
               if (req_if.func == FUNC_INSERT && cnt_ff >= CNT_W'(HALF)) begin
                  res_status_in = ST_FULL;
                  res_slot_in   = '0;
                  res_value_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  hash_start = 1'b1;
                  state_in   = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = hash_home;
               probe_addr_in = hash_home;
               probe_cnt_in  = '0;
               state_in      = S_PROBE;
            end
         end
         S_PROBE: begin
            res_slot_in  = SLOT_W'(probe_addr_ff);
            res_value_in = '0;
            state_in     = S_DONE;
            if (hit) begin
               if (insert_op) begin
                  res_status_in = ST_DUPLICATE;
               end else begin
                  res_status_in = ST_FOUND;
                  res_value_in  = mem_rd_data.value;
               end
            end else if (!mem_rd_data.used) begin
               if (insert_op) begin
                  mem_ctl.wr_en = 1'b1;
                  cnt_in        = cnt_ff + 1'b1;
                  res_status_in = ST_INSERTED;
               end else begin
                  res_status_in = ST_NOT_FOUND;
                  res_slot_in   = '0;
               end
            end else if (probe_cnt_ff == LAST) begin
               res_status_in = insert_op ? ST_FULL : ST_NOT_FOUND;
               res_slot_in   = '0;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = next_addr;
               probe_addr_in = next_addr;
               probe_cnt_in  = probe_cnt_ff + 1'b1;
               state_in      = S_PROBE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_func_ff    <= op_func_in;
      op_row_ff     <= op_row_in;
      op_col_ff     <= op_col_in;
      op_value_ff   <= op_value_in;
      probe_addr_ff <= probe_addr_in;
      probe_cnt_ff  <= probe_cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.slot      = rsp_slot_ff;
   assign rsp_if.value_out = rsp_value_ff;

   `LPHM_ASSERT_IMPL(a_count_bound, 1'b1, cnt_ff <= CNT_W'(HALF))
   `LPHM_ASSERT_IMPL(a_write_free, state_ff == S_PROBE && mem_ctl.wr_en, !mem_rd_data.used)
   `LPHM_ASSERT_NEXT(a_count_step, state_ff == S_PROBE && mem_ctl.wr_en,
                     cnt_ff == $past(cnt_ff) + 1'b1)
   `LPHM_ASSERT_IMPL(a_port_clash, mem_ctl.wr_en && mem_ctl.rd_en, mem_wr_addr != mem_rd_addr)
endmodule

`default_nettype wire

@@ rtl/core/linear_probe_hash_map.sv @@
// Linear-probing hash map, one operation item at a time.
// From accept, an item passes the hash, one probe state per slot probed, then the result state;
// a refused insert (table full) goes straight to the result state. Next item is accepted as the result is registered.
// A depth that is not a power of two uses the ROM-based home-slot reduction, which registers the ROM outputs first.
// Reset: synchronous; a sweep over every slot then clears the slot memory, req not ready.
// Depends on lphm_pkg, lphm_req_if, lphm_rsp_if, lphm_hash, lphm_mem, lphm_ctrl.
`default_nettype none

module linear_probe_hash_map #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   lphm_req_if.sink   req_if,
   lphm_rsp_if.source rsp_if
);
   import lphm_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic             hash_start;
   logic [ROW_W-1:0] hash_row;
   logic [COL_W-1:0] hash_col;
   logic             hash_done;
   logic [IDX_W-1:0] hash_home;
   mem_ctl_type      mem_ctl;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   lphm_hash #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key_row (hash_row),
      .key_col (hash_col),
      .done    (hash_done),
      .home    (hash_home)
   );

   lphm_mem #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lphm_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .hash_start  (hash_start),
      .hash_row    (hash_row),
      .hash_col    (hash_col),
      .hash_done   (hash_done),
      .hash_home   (hash_home),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );
endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_map: drives insert and lookup items,
// predicts every result with its own copy of the table and checks each result field.
// Depends on lphm_pkg, lphm_req_if, lphm_rsp_if and the linear_probe_hash_map RTL.

module tb;
   import lphm_pkg::*;

   localparam int MAP_DEPTH   = 1024;
   localparam int MAX_LOAD    = MAP_DEPTH / 2;
   localparam int RANDOM_OPS  = 1525;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int ERROR_PRINTS = 40;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } map_key_type;

   typedef struct {
      func_type           op;
      map_key_type        key;
      logic [VALUE_W-1:0] value;
      bit                 drain;
   } map_op_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
   } map_result_type;

   logic clock;
   logic reset;

   lphm_req_if req_if ();
   lphm_rsp_if rsp_if ();

   linear_probe_hash_map #(
      .TABLE_DEPTH(MAP_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // mirror of the table
   bit                 slot_taken [MAP_DEPTH];
   logic [ROW_W-1:0]   slot_row   [MAP_DEPTH];
   logic [COL_W-1:0]   slot_col   [MAP_DEPTH];
   logic [VALUE_W-1:0] slot_value [MAP_DEPTH];
   int                 entry_total;
   int                 longest_probe;

   map_op_type     op_backlog[$];
   map_result_type predicted_replies[$];

   int in_flight;
   int send_hold;
   int sent_cnt;
   int recv_hold;
   int recv_cnt;
   int cycle_cnt;
   int error_cnt;
   int status_tally[5];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int home_of(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      return (int'(row) * 31371 + int'(col) * 2689) % MAP_DEPTH;
   endfunction

   function automatic map_result_type apply_map_op(func_type op, map_key_type key,
                                                   logic [VALUE_W-1:0] value);
      map_result_type r;
      int             s;
      int             n;
      bit             done;
      r.status = ST_NOT_FOUND;
      r.slot   = '0;
      r.value  = '0;
      if (op == FUNC_INSERT && entry_total >= MAX_LOAD) begin
         r.status = ST_FULL;
      end else begin
         if (op == FUNC_INSERT) r.status = ST_FULL;
         s    = home_of(key.row, key.col);
         n    = 0;
         done = 1'b0;
         while (!done && n < MAP_DEPTH) begin
            n++;
            if (slot_taken[s] && slot_row[s] == key.row && slot_col[s] == key.col) begin
               r.status = (op == FUNC_INSERT) ? ST_DUPLICATE : ST_FOUND;
               r.slot   = s[SLOT_W-1:0];
               if (op == FUNC_LOOKUP) r.value = slot_value[s];
               done = 1'b1;
            end else if (!slot_taken[s]) begin
               if (op == FUNC_INSERT) begin
                  slot_taken[s] = 1'b1;
                  slot_row[s]   = key.row;
                  slot_col[s]   = key.col;
                  slot_value[s] = value;
                  entry_total++;
                  r.status = ST_INSERTED;
                  r.slot   = s[SLOT_W-1:0];
               end
               done = 1'b1;
            end else begin
               s = (s + 1) % MAP_DEPTH;
            end
         end
         if (n > longest_probe) longest_probe = n;
      end
      return r;
   endfunction

   // quiet stretches: every third block of items goes without waits
   function automatic int draw_wait(int n, int period);
      return ((n / period) % 3 == 1) ? 0 : int'($urandom_range(0, 18));
   endfunction

   task automatic flag_error(string msg);
      if (error_cnt < ERROR_PRINTS) $display("ERROR cycle %0d: %s", cycle_cnt, msg);
      error_cnt++;
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      map_op_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_hold    <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_hold != 0) begin
            send_hold    <= send_hold - 1;
            req_if.valid <= 1'b0;
         end else if (op_backlog.size() != 0 &&
                      !(op_backlog[0].drain &&
                        (in_flight + int'(req_if.valid && req_if.ready)
                         - int'(rsp_if.valid && rsp_if.ready)) != 0)) begin
            nxt = op_backlog.pop_front();
            req_if.valid    <= 1'b1;
            req_if.func     <= nxt.op;
            req_if.key_row  <= nxt.key.row;
            req_if.key_col  <= nxt.key.col;
            req_if.value_in <= nxt.value;
            send_hold       <= draw_wait(sent_cnt, 50);
            sent_cnt        <= sent_cnt + 1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin : drive_rsp
      int s;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_hold    <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         s = draw_wait(recv_cnt, 70);
         rsp_if.ready <= (s == 0);
         recv_hold    <= (s == 0) ? 0 : s - 1;
         recv_cnt     <= recv_cnt + 1;
      end else if (!rsp_if.ready) begin
         if (recv_hold == 0) rsp_if.ready <= 1'b1;
         else recv_hold <= recv_hold - 1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin : check_map
      map_result_type want;
      map_key_type    key;
      if (reset) begin
         in_flight <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_replies.size() == 0) begin
               flag_error("result item with no prediction pending");
            end else begin
               want = predicted_replies.pop_front();
               status_tally[int'(want.status)]++;
               if (rsp_if.status !== want.status)
                  flag_error($sformatf("status %0d, expected %s", rsp_if.status,
                                       want.status.name()));
               if (rsp_if.slot !== want.slot)
                  flag_error($sformatf("slot %0d, expected %0d", rsp_if.slot, want.slot));
               if (rsp_if.value_out !== want.value)
                  flag_error($sformatf("value_out %h, expected %h", rsp_if.value_out,
                                       want.value));
            end
         end
         if (req_if.valid && req_if.ready) begin
            key.row = req_if.key_row;
            key.col = req_if.key_col;
            predicted_replies.push_back(apply_map_op(func_type'(req_if.func), key,
                                                     req_if.value_in));
         end
         in_flight <= in_flight + int'(req_if.valid && req_if.ready)
                      - int'(rsp_if.valid && rsp_if.ready);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("** linear_probe_hash_map: FAILED **");
         $finish;
      end
   end

   map_key_type issued[$];
   logic [ROW_W-1:0]  cluster_row[4];
   logic [SLOT_W-1:0] cluster_low[4];

   task automatic add_op(func_type op, map_key_type key, logic [VALUE_W-1:0] value,
                         bit drain);
      map_op_type item;
      item.op    = op;
      item.key   = key;
      item.value = value;
      item.drain = drain;
      op_backlog.push_back(item);
      if (op == FUNC_INSERT) issued.push_back(key);
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      return VALUE_W'({$urandom, $urandom});
   endfunction

   function automatic map_key_type cluster_key();
      map_key_type k;
      int          idx;
      idx   = $urandom_range(0, 3);
      k.row = cluster_row[idx];
      k.col = {6'($urandom), cluster_low[idx]};
      return k;
   endfunction

   function automatic map_key_type any_key();
      map_key_type k;
      k.row = ROW_W'($urandom);
      k.col = COL_W'($urandom);
      return k;
   endfunction

   initial begin : run
      map_key_type k;
      int          wrap_col;
      int          roll;
      int          pick;
      int          c;
      func_type    op;

      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.func     = FUNC_INSERT;
      req_if.key_row  = '0;
      req_if.key_col  = '0;
      req_if.value_in = '0;
      rsp_if.ready    = 1'b0;
      cycle_cnt       = 0;
      error_cnt       = 0;
      sent_cnt        = 0;
      recv_cnt        = 0;
      entry_total     = 0;
      longest_probe   = 0;
      in_flight       = 0;
      foreach (status_tally[i]) status_tally[i] = 0;

      // key whose home is the last slot, so its chain wraps to slot 0
      wrap_col = 0;
      for (c = 0; c < MAP_DEPTH; c++)
         if (home_of(8'd0, COL_W'(c)) == MAP_DEPTH - 1) wrap_col = c;

      cluster_row[0] = '0;
      cluster_low[0] = SLOT_W'(wrap_col);
      for (c = 1; c < 4; c++) begin
         cluster_row[c] = ROW_W'($urandom);
         cluster_low[c] = SLOT_W'($urandom);
      end

      // directed part
      add_op(FUNC_LOOKUP, '{8'd0, 16'd0}, rand_value(), 1'b0);
      add_op(FUNC_INSERT, '{8'd0, 16'd0}, '0, 1'b0);
      add_op(FUNC_INSERT, '{8'hFF, 16'hFFFF}, '1, 1'b0);
      add_op(FUNC_LOOKUP, '{8'd0, 16'd0}, '1, 1'b0);
      add_op(FUNC_LOOKUP, '{8'hFF, 16'hFFFF}, '0, 1'b0);
      add_op(FUNC_INSERT, '{8'd0, 16'd0}, rand_value(), 1'b0);
      add_op(FUNC_INSERT, '{8'hFF, 16'hFFFF}, '0, 1'b0);
      add_op(FUNC_INSERT, '{8'd0, COL_W'(wrap_col)},
             VALUE_W'({(VALUE_W+1)/2{2'b01}}), 1'b0);
      add_op(FUNC_INSERT, '{8'd0, COL_W'(wrap_col + 1024)},
             VALUE_W'({(VALUE_W+1)/2{2'b10}}), 1'b0);
      add_op(FUNC_INSERT, '{8'd0, COL_W'(wrap_col + 2048)}, rand_value(), 1'b1);
      add_op(FUNC_LOOKUP, '{8'd0, COL_W'(wrap_col)}, '0, 1'b0);
      add_op(FUNC_LOOKUP, '{8'd0, COL_W'(wrap_col + 1024)}, '0, 1'b0);
      add_op(FUNC_LOOKUP, '{8'd0, COL_W'(wrap_col + 2048)}, '0, 1'b0);
      add_op(FUNC_LOOKUP, '{8'd0, COL_W'(wrap_col + 3072)}, '0, 1'b0);
      add_op(FUNC_INSERT, '{8'd0, COL_W'(wrap_col + 2048)}, rand_value(), 1'b0);
      add_op(FUNC_INSERT, '{8'h80, 16'h8000}, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
      add_op(FUNC_LOOKUP, '{8'h80, 16'h8000}, '0, 1'b0);
      add_op(FUNC_LOOKUP, '{8'h7F, 16'h7FFF}, '1, 1'b0);
      add_op(FUNC_INSERT, '{8'h01, 16'h0001}, 63'd1, 1'b0);
      add_op(FUNC_LOOKUP, '{8'h01, 16'h0001}, '0, 1'b0);

      // random part: mostly live keys and colliding keys, pushing inserts against the half-load limit
      for (c = 0; c < RANDOM_OPS; c++) begin
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 99);
         op   = (roll < 55) ? FUNC_INSERT : FUNC_LOOKUP;
         if (op == FUNC_INSERT) begin
            if (pick < 20) k = issued[$urandom_range(0, issued.size() - 1)];
            else if (pick < 55) k = cluster_key();
            else k = any_key();
         end else begin
            if (pick < 60) k = issued[$urandom_range(0, issued.size() - 1)];
            else if (pick < 80) k = any_key();
            else k = cluster_key();
         end
         add_op(op, k, rand_value(), (c == 0) || ($urandom_range(0, 199) == 0));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!(op_backlog.size() == 0 && !req_if.valid && in_flight == 0))
         @(negedge clock);
      repeat (64) @(posedge clock);

      if (predicted_replies.size() != 0)
         flag_error($sformatf("%0d predicted results never arrived",
                              predicted_replies.size()));

      $display("Covered %0d items: %0d inserted, %0d duplicate, %0d refused full,",
               sent_cnt, status_tally[ST_INSERTED], status_tally[ST_DUPLICATE],
               status_tally[ST_FULL]);
      $display("%0d found, %0d not found; final load %0d of %0d slots, longest probe %0d.",
               status_tally[ST_FOUND], status_tally[ST_NOT_FOUND], entry_total, MAP_DEPTH,
               longest_probe);
      if (error_cnt == 0) begin
         $display("** linear_probe_hash_map: PASSED **");
      end else begin
         $display("** linear_probe_hash_map: FAILED **");
      end
      $finish;
   end
endmodule
